### rtl/crw_pkg.sv
// Package: sizes, codes and shared types of the CSR random walk step core
`timescale 1ns / 1ps
package crw_pkg;

	// Graph capacity
	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 8192;
	localparam int OFS_DEPTH = MAX_NODES + 1;

	// Field and internal widths
	localparam int FUNC_W = 2;
	localparam int IDX_W  = 13;
	localparam int VAL_W  = 14;
	localparam int RND_W  = 32;
	localparam int NODE_W = 10;
	localparam int CNT_W  = 11;
	localparam int OFS_AW = 11;
	localparam int NBR_AW = 13;
	localparam int DEG_W  = VAL_W;
	localparam int PROD_W = RND_W + DEG_W;
	localparam int SUM_W  = VAL_W + 1;

	// Register port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(1024);

	// Item function codes
	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD_OFS = 2'd0,
		FN_LOAD_NBR = 2'd1,
		FN_START    = 2'd2,
		FN_STEP     = 2'd3
	} func_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_RD,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic mul_en;
		logic rd_en;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

### rtl/crw_if.sv
// Interfaces: input item channel and result item channel
`timescale 1ns / 1ps
interface crw_in_if;
	logic                      valid;
	logic                      ready;
	logic [crw_pkg::FUNC_W-1:0] func;
	logic [crw_pkg::IDX_W-1:0]  index;
	logic [crw_pkg::VAL_W-1:0]  value;
	logic [crw_pkg::RND_W-1:0]  random_word;

	modport source (output valid, func, index, value, random_word, input ready);
	modport sink (input valid, func, index, value, random_word, output ready);
endinterface

interface crw_out_if;
	logic                       valid;
	logic                       ready;
	logic [crw_pkg::NODE_W-1:0] node_id;
	logic                       isolated;
	logic                       bad_start;

	modport source (output valid, node_id, isolated, bad_start, input ready);
	modport sink (input valid, node_id, isolated, bad_start, output ready);
endinterface

### rtl/csr_uniform_random_walk_step_core.sv
// Top level: CSR graph random walk step core with register port
//
//  channel  | dir | payload                                | handshake
//  ---------+-----+----------------------------------------+-------------
//  in_ch    | in  | func, index, value, random_word        | valid/ready
//  out_ch   | out | node_id, isolated, bad_start           | valid/ready
//  apb      | in  | node_count at byte address 0           | psel/penable
//
// A load item leaves the core ready for the next item. A start item goes
// straight to result write; a step item goes through offset pair read, pick
// multiply, neighbour read and result write, following its chain of dependent table reads.
// A finished result waits in the output register; the next item is taken
// while it waits, and the core holds in its last state only if the
// register is still full when another result is ready.
// Reset clears the current node to zero and node_count to 1024; table
// contents are undefined until loaded.
`timescale 1ns / 1ps
module csr_uniform_random_walk_step_core (
	input  logic                        clk,
	input  logic                        arst_n,
	crw_in_if.sink                      in_ch,
	crw_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [crw_pkg::APB_AW-1:0]  paddr,
	input  logic [crw_pkg::APB_DW-1:0]  pwdata,
	output logic [crw_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	crw_pkg::cmd_t             cmd;
	crw_pkg::sts_t             sts;
	logic [crw_pkg::CNT_W-1:0] node_count_q;
	logic                      reg_sel;

	// Register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == crw_pkg::REG_NODE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= crw_pkg::NODE_COUNT_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			node_count_q <= pwdata[crw_pkg::CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? crw_pkg::APB_DW'(node_count_q) : '0;

	// Controller
	crw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_func  (in_ch.func),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	crw_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_func        (in_ch.func),
		.in_index       (in_ch.index),
		.in_value       (in_ch.value),
		.in_random_word (in_ch.random_word),
		.node_count     (node_count_q),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_node_id    (out_ch.node_id),
		.out_isolated   (out_ch.isolated),
		.out_bad_start  (out_ch.bad_start)
	);

	// A load item never keeps the core busy
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready
			&& (in_ch.func == crw_pkg::FN_LOAD_OFS || in_ch.func == crw_pkg::FN_LOAD_NBR))
		|=> in_ch.ready)
		else $error("load item left the core busy");

	// A step item holds off new items through its read and multiply cycles
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.func == crw_pkg::FN_STEP)
		|=> !in_ch.ready ##1 !in_ch.ready)
		else $error("step item overlapped by a new item");

	// A result is never both a refused start and an isolated step
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.isolated && out_ch.bad_start))
		else $error("isolated and bad_start set together");

endmodule

### rtl/crw_ctrl.sv
// Controller: sequences load, start and step items through the datapath
`timescale 1ns / 1ps
module crw_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [crw_pkg::FUNC_W-1:0] in_func,
	output logic                       in_ready,
	input  crw_pkg::sts_t              sts,
	output crw_pkg::cmd_t              cmd
);

	crw_pkg::state_t state_q;
	crw_pkg::state_t state_nxt;
	logic            accept;

	assign in_ready = (state_q == crw_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crw_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			crw_pkg::ST_IDLE: begin
				if (accept) begin
					case (crw_pkg::func_t'(in_func))
						crw_pkg::FN_START: state_nxt = crw_pkg::ST_DONE;
						crw_pkg::FN_STEP:  state_nxt = crw_pkg::ST_MUL;
						default:           state_nxt = crw_pkg::ST_IDLE;
					endcase
				end
			end
			crw_pkg::ST_MUL: state_nxt = crw_pkg::ST_RD;
			crw_pkg::ST_RD:  state_nxt = crw_pkg::ST_DONE;
			crw_pkg::ST_DONE: begin
				if (sts.out_free) state_nxt = crw_pkg::ST_IDLE;
			end
			default: state_nxt = crw_pkg::ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		case (state_q)
			crw_pkg::ST_MUL:  cmd.mul_en = 1'b1;
			crw_pkg::ST_RD:   cmd.rd_en = 1'b1;
			crw_pkg::ST_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

### rtl/crw_dp.sv
// Datapath: graph tables, current node, neighbour pick and result register
`timescale 1ns / 1ps
module crw_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  crw_pkg::cmd_t               cmd,
	output crw_pkg::sts_t               sts,
	input  logic [crw_pkg::FUNC_W-1:0]  in_func,
	input  logic [crw_pkg::IDX_W-1:0]   in_index,
	input  logic [crw_pkg::VAL_W-1:0]   in_value,
	input  logic [crw_pkg::RND_W-1:0]   in_random_word,
	input  logic [crw_pkg::CNT_W-1:0]   node_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [crw_pkg::NODE_W-1:0]  out_node_id,
	output logic                        out_isolated,
	output logic                        out_bad_start
);

	// Tables; contents undefined until loaded
	logic [crw_pkg::VAL_W-1:0]  ofs_mem [0:crw_pkg::OFS_DEPTH-1];
	logic [crw_pkg::NODE_W-1:0] nbr_mem [0:crw_pkg::MAX_EDGES-1];

	logic [crw_pkg::NODE_W-1:0] cur_q;
	logic                       is_step_q;
	logic [crw_pkg::VAL_W-1:0]  value_q;
	logic [crw_pkg::RND_W-1:0]  rnd_q;
	logic [crw_pkg::VAL_W-1:0]  ofs_lo_q;
	logic [crw_pkg::VAL_W-1:0]  ofs_hi_q;
	logic [crw_pkg::VAL_W-1:0]  pick_q;
	logic                       deg_ok_q;
	logic                       step_ok_q;
	logic [crw_pkg::NODE_W-1:0] nbr_rd_q;
	logic                       out_valid_q;
	logic [crw_pkg::NODE_W-1:0] out_node_q;
	logic                       out_iso_q;
	logic                       out_bad_q;

	logic [crw_pkg::OFS_AW-1:0] cur_ext;
	logic                       wr_ofs;
	logic                       wr_nbr;
	logic [crw_pkg::DEG_W-1:0]  deg;
	logic [crw_pkg::PROD_W-1:0] prod;
	logic [crw_pkg::SUM_W-1:0]  nbr_addr;
	logic                       start_ok;
	logic [crw_pkg::NODE_W-1:0] node_nxt;

	// Load decode
	assign wr_ofs = cmd.accept && (crw_pkg::func_t'(in_func) == crw_pkg::FN_LOAD_OFS)
		&& (in_index < crw_pkg::IDX_W'(crw_pkg::OFS_DEPTH));
	assign wr_nbr = cmd.accept && (crw_pkg::func_t'(in_func) == crw_pkg::FN_LOAD_NBR)
		&& (32'(in_index) < 32'(crw_pkg::MAX_EDGES));

	// cur+1 always falls inside the offset table, as cur is below MAX_NODES
	assign cur_ext = crw_pkg::OFS_AW'(cur_q);

	// Offset table: one write port, two read ports (cur and cur+1)
	always_ff @(posedge clk) begin
		if (wr_ofs) ofs_mem[in_index[crw_pkg::OFS_AW-1:0]] <= in_value;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ofs_lo_q <= ofs_mem[cur_ext];
			ofs_hi_q <= ofs_mem[cur_ext + crw_pkg::OFS_AW'(1)];
		end
	end

	// Neighbour table: one write port, one read port
	always_ff @(posedge clk) begin
		if (wr_nbr) nbr_mem[in_index[crw_pkg::NBR_AW-1:0]] <= in_value[crw_pkg::NODE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) nbr_rd_q <= nbr_mem[nbr_addr[crw_pkg::NBR_AW-1:0]];
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			is_step_q <= (crw_pkg::func_t'(in_func) == crw_pkg::FN_STEP);
			value_q   <= in_value;
			rnd_q     <= in_random_word;
		end
	end

	// Degree and scaled pick: (random * degree) >> 32
	assign deg  = ofs_hi_q - ofs_lo_q;
	assign prod = crw_pkg::PROD_W'(rnd_q) * crw_pkg::PROD_W'(deg);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			pick_q   <= prod[crw_pkg::PROD_W-1:crw_pkg::RND_W];
			deg_ok_q <= (ofs_hi_q > ofs_lo_q);
		end
	end

	// Neighbour address and range check
	assign nbr_addr = crw_pkg::SUM_W'(ofs_lo_q) + crw_pkg::SUM_W'(pick_q);

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			step_ok_q <= deg_ok_q && (nbr_addr < crw_pkg::SUM_W'(crw_pkg::MAX_EDGES));
		end
	end

	// Start check and next node
	assign start_ok = (value_q < crw_pkg::VAL_W'(node_count))
		&& (value_q < crw_pkg::VAL_W'(crw_pkg::MAX_NODES));

	always_comb begin
		if (is_step_q) begin
			node_nxt = step_ok_q ? nbr_rd_q : cur_q;
		end else begin
			node_nxt = start_ok ? value_q[crw_pkg::NODE_W-1:0] : cur_q;
		end
	end

	// Current node
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cmd.out_load) begin
			cur_q <= node_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_node_q <= node_nxt;
			out_iso_q  <= is_step_q && !step_ok_q;
			out_bad_q  <= !is_step_q && !start_ok;
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_node_id   = out_node_q;
	assign out_isolated  = out_iso_q;
	assign out_bad_start = out_bad_q;

endmodule

### dv/csr_uniform_random_walk_step_core_test.sv
// Testbench: CSR random walk step core, graph loads, walks and node_count limits
`timescale 1ns / 1ps
module csr_uniform_random_walk_step_core_test;
	import crw_pkg::*;

	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		func_t             func;
		logic [IDX_W-1:0]  index;
		logic [VAL_W-1:0]  value;
		logic [RND_W-1:0]  random_word;
	} walk_item_t;

	typedef struct {
		logic [NODE_W-1:0] node_id;
		logic              isolated;
		logic              bad_start;
	} walk_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	crw_in_if  in_ch ();
	crw_out_if out_ch ();

	csr_uniform_random_walk_step_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the graph and walk state
	logic [VAL_W-1:0]  ofs_tbl [OFS_DEPTH];
	logic [NODE_W-1:0] nbr_tbl [MAX_EDGES];
	bit                ofs_written [OFS_DEPTH];
	bit                nbr_written [MAX_EDGES];
	logic [NODE_W-1:0] walk_node = '0;
	logic [CNT_W-1:0]  cfg_node_count = NODE_COUNT_RST;

	walk_result_t pending_walk_results [$];
	int counted_items = 0;
	int error_count = 0;
	int src_idle_pct = 13;
	int snk_idle_pct = 86;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#(5_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side back-pressure
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// Neighbour slot picked by a random word: lo + (rnd * degree) >> 32
	function automatic int edge_slot(input int lo, input int hi, input logic [RND_W-1:0] rnd);
		longint unsigned prod;
		prod = longint'(rnd) * longint'(hi - lo);
		return lo + int'(prod >> 32);
	endfunction

	// True when a step with this word touches only entries already loaded
	function automatic bit step_reads_written(input logic [RND_W-1:0] rnd);
		int lo;
		int hi;
		int slot;
		if (!ofs_written[walk_node] || !ofs_written[int'(walk_node) + 1])
			return 1'b0;
		lo = ofs_tbl[walk_node];
		hi = ofs_tbl[int'(walk_node) + 1];
		if (hi <= lo)
			return 1'b1;
		slot = edge_slot(lo, hi, rnd);
		return (slot >= MAX_EDGES) || nbr_written[slot];
	endfunction

	function automatic logic [RND_W-1:0] pick_random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return RND_W'($urandom_range(0, 255));
			default: return RND_W'($urandom);
		endcase
	endfunction

	// Walk predictor: updates the shadow state, queues the result if any
	task automatic predict_walk_item(input walk_item_t it);
		walk_result_t res;
		int lo;
		int hi;
		int slot;
		res.node_id = '0;
		res.isolated = 1'b0;
		res.bad_start = 1'b0;
		case (it.func)
			FN_LOAD_OFS: begin
				if (it.index < OFS_DEPTH) begin
					ofs_tbl[it.index] = it.value;
					ofs_written[it.index] = 1'b1;
				end
			end
			FN_LOAD_NBR: begin
				if (it.index < MAX_EDGES) begin
					nbr_tbl[it.index] = it.value[NODE_W-1:0];
					nbr_written[it.index] = 1'b1;
				end
			end
			FN_START: begin
				if (it.value < cfg_node_count && it.value < MAX_NODES)
					walk_node = it.value[NODE_W-1:0];
				else
					res.bad_start = 1'b1;
			end
			default: begin
				// a 10-bit node always has its offset pair inside the table
				res.isolated = 1'b1;
				lo = ofs_tbl[walk_node];
				hi = ofs_tbl[int'(walk_node) + 1];
				if (hi > lo) begin
					slot = edge_slot(lo, hi, it.random_word);
					if (slot < MAX_EDGES) begin
						walk_node = nbr_tbl[slot];
						res.isolated = 1'b0;
					end
				end
			end
		endcase
		if (it.func == FN_START || it.func == FN_STEP) begin
			res.node_id = walk_node;
			pending_walk_results.push_back(res);
		end
	endtask

	// Send one item; entered and left at a falling edge
	task automatic send_walk_item(input func_t func, input int index, input int value,
			input logic [RND_W-1:0] rnd);
		walk_item_t it;
		it.func = func;
		it.index = IDX_W'(index);
		it.value = VAL_W'(value);
		it.random_word = rnd;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.func = it.func;
		in_ch.index = it.index;
		in_ch.value = it.value;
		in_ch.random_word = it.random_word;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_walk_item(it);
		if (!(func == FN_LOAD_OFS && it.index >= OFS_DEPTH))
			counted_items++;
		@(negedge clk);
	endtask

	// Hold the input back until every queued result is out, then let loads finish
	task automatic wait_results_drained();
		in_ch.valid = 1'b0;
		while (pending_walk_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write: setup then access phase
	task automatic write_node_count(input int count);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = APB_AW'(4 * REG_NODE_COUNT);
		pwdata = APB_DW'(count);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		cfg_node_count = CNT_W'(count);
	endtask

	// Step if every read is to a loaded entry, else restart inside the window
	task automatic send_step_or_restart(input int base, input int nodes);
		logic [RND_W-1:0] rnd;
		rnd = pick_random_word();
		if (step_reads_written(rnd))
			send_walk_item(FN_STEP, $urandom, $urandom, rnd);
		else
			send_walk_item(FN_START, $urandom, base + $urandom_range(0, nodes - 1), $urandom);
	endtask

	task automatic send_noise_item(input int base, input int nodes);
		case ($urandom_range(0, 3))
			0: send_walk_item(FN_LOAD_OFS, $urandom, $urandom, $urandom);
			1: send_walk_item(FN_LOAD_NBR, $urandom, $urandom, $urandom);
			2: send_walk_item(FN_START, $urandom, $urandom, $urandom);
			default: send_step_or_restart(base, nodes);
		endcase
	endtask

	// Hand-built graphs covering the corner cases
	task automatic test_directed_walks();
		// node 0 -> {1, 2}, node 1 -> {0}, node 2 has no edges
		send_walk_item(FN_LOAD_OFS, 0, 0, '0);
		send_walk_item(FN_LOAD_OFS, 1, 2, '0);
		send_walk_item(FN_LOAD_OFS, 2, 3, '0);
		send_walk_item(FN_LOAD_OFS, 3, 3, '0);
		send_walk_item(FN_LOAD_NBR, 0, 1, '0);
		send_walk_item(FN_LOAD_NBR, 1, 2, '0);
		send_walk_item(FN_LOAD_NBR, 2, 0, '0);
		// top node owns the last slot; stored id keeps its low bits only
		send_walk_item(FN_LOAD_OFS, MAX_NODES - 1, MAX_EDGES - 1, '0);
		send_walk_item(FN_LOAD_OFS, MAX_NODES, MAX_EDGES, '0);
		send_walk_item(FN_LOAD_NBR, MAX_EDGES - 1, 16383, '1);
		// offset write beyond the table is dropped
		send_walk_item(FN_LOAD_OFS, 8191, 16383, '1);
		send_walk_item(FN_START, 8191, 0, '1);
		send_walk_item(FN_STEP, 0, 0, '0);
		send_walk_item(FN_STEP, 8191, 16383, '1);
		send_walk_item(FN_STEP, 0, 0, '1);
		send_walk_item(FN_STEP, 0, 0, RND_W'($urandom));
		send_walk_item(FN_START, 0, MAX_NODES - 1, '0);
		send_walk_item(FN_STEP, 0, 0, '1);
		send_walk_item(FN_START, 0, MAX_NODES, '0);
		// reversed offset pair, then an edge range running past the neighbour table
		send_walk_item(FN_LOAD_OFS, 4, 5, '0);
		send_walk_item(FN_LOAD_OFS, 5, 2, '0);
		send_walk_item(FN_LOAD_OFS, 6, 9000, '0);
		send_walk_item(FN_START, 0, 4, '0);
		send_walk_item(FN_STEP, 0, 0, RND_W'($urandom));
		send_walk_item(FN_START, 0, 5, '0);
		send_walk_item(FN_STEP, 0, 0, '1);
	endtask

	// node_count at both ends of its range
	task automatic test_node_count_limits();
		wait_results_drained();
		write_node_count(1);
		send_walk_item(FN_START, 0, 0, '0);
		send_walk_item(FN_START, 0, 1, '0);
		send_walk_item(FN_START, 0, 16383, '0);
		wait_results_drained();
		write_node_count(MAX_NODES);
		send_walk_item(FN_START, 0, MAX_NODES - 1, '0);
		send_walk_item(FN_START, 0, MAX_NODES, '0);
	endtask

	// Random graphs on windows of node ids, walked with random words plus noise
	task automatic test_random_walks(input int src_pct, input int snk_pct, input int node_cnt,
			input int item_target);
		int stop_at;
		int limit;
		int base;
		int nodes;
		int total;
		int edge_lo;
		int acc;
		int k;
		int degs [16];
		wait_results_drained();
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		write_node_count(node_cnt);
		limit = (node_cnt < MAX_NODES) ? node_cnt : MAX_NODES;
		stop_at = counted_items + item_target;
		while (counted_items < stop_at) begin
			nodes = $urandom_range(2, 8);
			base = ($urandom_range(0, 7) == 0) ? limit - nodes : $urandom_range(0, limit - nodes);
			total = 0;
			for (k = 0; k < nodes; k++) begin
				degs[k] = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
				total += degs[k];
			end
			edge_lo = ($urandom_range(0, 7) == 0) ? MAX_EDGES - total
				: $urandom_range(0, MAX_EDGES - total);
			// offsets, then neighbours, some with spare high bits set
			acc = edge_lo;
			for (k = 0; k <= nodes; k++) begin
				send_walk_item(FN_LOAD_OFS, base + k, acc, $urandom);
				if (k < nodes)
					acc += degs[k];
			end
			for (k = edge_lo; k < edge_lo + total; k++)
				send_walk_item(FN_LOAD_NBR, k, base + $urandom_range(0, nodes - 1)
					+ (($urandom_range(0, 3) == 0) ? ($urandom_range(1, 15) << NODE_W) : 0),
					$urandom);
			// walk it
			send_walk_item(FN_START, $urandom, base + $urandom_range(0, nodes - 1), $urandom);
			repeat ($urandom_range(6, 24)) begin
				if ($urandom_range(0, 9) == 0)
					send_noise_item(base, nodes);
				else
					send_step_or_restart(base, nodes);
			end
			if ($urandom_range(0, 3) == 0)
				wait_results_drained();
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		walk_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_walk_results.size() == 0) begin
				$error("unexpected result item: node_id %0d isolated %0b bad_start %0b",
					out_ch.node_id, out_ch.isolated, out_ch.bad_start);
				error_count++;
			end else begin
				want = pending_walk_results.pop_front();
				if (out_ch.node_id !== want.node_id) begin
					$error("node_id: expected %0d, got %0d", want.node_id, out_ch.node_id);
					error_count++;
				end
				if (out_ch.isolated !== want.isolated) begin
					$error("isolated: expected %0b, got %0b", want.isolated, out_ch.isolated);
					error_count++;
				end
				if (out_ch.bad_start !== want.bad_start) begin
					$error("bad_start: expected %0b, got %0b", want.bad_start, out_ch.bad_start);
					error_count++;
				end
			end
		end
	end

	// Test sequence
	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = FN_LOAD_OFS;
		in_ch.index = '0;
		in_ch.value = '0;
		in_ch.random_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_directed_walks();
		test_node_count_limits();
		test_random_walks(13, 86, MAX_NODES, 130);
		test_random_walks(86, 13, $urandom_range(64, MAX_NODES - 1), 130);
		test_random_walks(0, 0, MAX_NODES, 130);
		wait_results_drained();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
